>>> hw/rtl/sha_pkg.sv
`timescale 1ns / 1ps
package sha_pkg;

  typedef logic [31:0]      sha_word_t;
  typedef logic [7:0][31:0] sha_state_t;  // [0] = a / H0

  typedef struct packed {
    logic       push;
    logic [7:0] data;
    logic       start;
    logic       reinit;
  } sha_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sha_stat_t;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] FILL_LAST = 6'd63;

  localparam sha_state_t SHA_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam sha_word_t SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

>>> hw/rtl/sha_stream_if.sv
`timescale 1ns / 1ps
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       message_end;

  modport source (output valid, output data_byte, output has_byte, output message_end,
                  input ready);
  modport sink (input valid, input data_byte, input has_byte, input message_end,
                output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

>>> hw/rtl/sha_round.sv
`timescale 1ns / 1ps
module sha_round import sha_pkg::*; (
  input  sha_state_t work_i,
  input  sha_word_t  w0_i,
  input  sha_word_t  w1_i,
  input  sha_word_t  w9_i,
  input  sha_word_t  w14_i,
  input  sha_word_t  k_i,
  input  logic       ext_i,
  output sha_state_t work_o,
  output sha_word_t  wt_o
);

  function automatic sha_word_t rotr(input sha_word_t v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  sha_word_t s0, s1, big0, big1, ch, maj, t1, wt;

  always_comb begin
    s0   = rotr(w1_i, 7) ^ rotr(w1_i, 18) ^ (w1_i >> 3);
    s1   = rotr(w14_i, 17) ^ rotr(w14_i, 19) ^ (w14_i >> 10);
    wt   = ext_i ? (w0_i + s0 + w9_i + s1) : w0_i;
    big1 = rotr(work_i[4], 6) ^ rotr(work_i[4], 11) ^ rotr(work_i[4], 25);
    ch   = (work_i[4] & work_i[5]) ^ (~work_i[4] & work_i[6]);
    t1   = work_i[7] + big1 + ch + k_i + wt;
    big0 = rotr(work_i[0], 2) ^ rotr(work_i[0], 13) ^ rotr(work_i[0], 22);
    maj  = (work_i[0] & work_i[1]) ^ (work_i[0] & work_i[2]) ^ (work_i[1] & work_i[2]);
    work_o    = {work_i[6], work_i[5], work_i[4], work_i[3] + t1,
                 work_i[2], work_i[1], work_i[0], t1 + big0 + maj};
    wt_o      = wt;
  end

endmodule

>>> hw/rtl/sha_core.sv
`timescale 1ns / 1ps
module sha_core import sha_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  sha_ctrl_t  ctrl,
  output sha_stat_t  stat,
  output sha_state_t chain
);

  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD} core_state_t;

  core_state_t state_r;
  logic [5:0]  t_r;
  sha_state_t  chain_r;
  sha_state_t  work_r;
  sha_state_t  work_nxt;
  sha_word_t   win_r [16];
  sha_word_t   wt;

  sha_round u_round (
    .work_i (work_r),
    .w0_i   (win_r[0]),
    .w1_i   (win_r[1]),
    .w9_i   (win_r[9]),
    .w14_i  (win_r[14]),
    .k_i    (SHA_K[t_r]),
    .ext_i  (t_r[5] | t_r[4]),
    .work_o (work_nxt),
    .wt_o   (wt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      t_r     <= '0;
      chain_r <= SHA_IV;
    end else begin
      unique case (state_r)
        C_IDLE: begin
          if (ctrl.reinit) chain_r <= SHA_IV;
          if (ctrl.start) begin
            t_r     <= '0;
            state_r <= C_ROUND;
          end
        end
        C_ROUND: begin
          t_r <= t_r + 6'd1;
          if (t_r == 6'd63) state_r <= C_ADD;
        end
        C_ADD: begin
          for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + work_r[i];
          state_r <= C_IDLE;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  // 512-bit line: bytes shift in at the bottom, window words shift toward slot 0
  always_ff @(posedge clk) begin
    if (state_r == C_IDLE && ctrl.start) work_r <= chain_r;
    else if (state_r == C_ROUND) work_r <= work_nxt;

    if (ctrl.push) begin
      for (int i = 0; i < 15; i++) win_r[i] <= {win_r[i][23:0], win_r[i+1][31:24]};
      win_r[15] <= {win_r[15][23:0], ctrl.data};
    end else if (state_r == C_ROUND) begin
      for (int i = 0; i < 15; i++) win_r[i] <= win_r[i+1];
      win_r[15] <= wt;
    end
  end

  assign stat.busy = (state_r != C_IDLE);
  assign stat.done = (state_r == C_ADD);
  assign chain     = chain_r;

endmodule

>>> hw/rtl/sha256_message_digest_top.sv
`timescale 1ns / 1ps
// channel      | dir | payload                                   | transfer
// in_stream    | in  | data_byte[7:0], has_byte, message_end      | valid & ready
// out_stream   | out | digest_word[31:0], word_index[2:0], last   | valid & ready
//
// A byte item is taken whenever in_stream.ready is high; every 64th byte adds a
// compression (start, 64 rounds on the shared round unit, chaining add). A message
// end pushes padding and length bytes and runs one or two compressions, then
// presents eight digest words. Reset is synchronous, active low, with no clearing pass.
// in_stream.ready is low while a block, padding or digest output is in progress;
// out_stream stalls hold the current word.
module sha256_message_digest_top import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sha_in_if.sink      in_stream,
  sha_out_if.source   out_stream
);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_WAIT, S_PAD80, S_PADZ, S_LEN, S_OUT
  } top_state_t;

  top_state_t  state_r;
  logic [5:0]  fill_r;
  logic [63:0] len_r;
  logic [2:0]  cnt_r;
  logic [2:0]  idx_r;
  logic        pend_end_r;
  logic        padding_r;
  logic        final_r;

  sha_ctrl_t   ctrl;
  sha_stat_t   stat;
  sha_state_t  chain;

  sha_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .stat  (stat),
    .chain (chain)
  );

  always_comb begin
    ctrl = '0;
    unique case (state_r)
      S_IDLE: begin
        ctrl.push = in_stream.valid & in_stream.has_byte;
        ctrl.data = in_stream.data_byte;
      end
      S_START: ctrl.start = 1'b1;
      S_PAD80: begin
        ctrl.push = 1'b1;
        ctrl.data = PAD_BYTE;
      end
      S_PADZ:  ctrl.push = (fill_r != LEN_START);
      S_LEN: begin
        ctrl.push = 1'b1;
        ctrl.data = len_r[{~cnt_r, 3'b000} +: 8];
      end
      S_OUT:   ctrl.reinit = out_stream.ready && (idx_r == 3'd7);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fill_r     <= '0;
      len_r      <= '0;
      cnt_r      <= '0;
      idx_r      <= '0;
      pend_end_r <= 1'b0;
      padding_r  <= 1'b0;
      final_r    <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_stream.valid) begin
            if (in_stream.has_byte) begin
              fill_r <= fill_r + 6'd1;
              len_r  <= len_r + 64'd8;
            end
            if (in_stream.has_byte && fill_r == FILL_LAST) begin
              pend_end_r <= in_stream.message_end;
              state_r    <= S_START;
            end else if (in_stream.message_end) begin
              state_r <= S_PAD80;
            end
          end
        end
        S_START: state_r <= S_WAIT;
        S_WAIT: begin
          if (stat.done) begin
            priority if (final_r) begin
              idx_r   <= '0;
              state_r <= S_OUT;
            end else if (padding_r) begin
              state_r <= S_PADZ;
            end else if (pend_end_r) begin
              state_r <= S_PAD80;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_PAD80: begin
          fill_r     <= fill_r + 6'd1;
          padding_r  <= 1'b1;
          pend_end_r <= 1'b0;
          state_r    <= (fill_r == FILL_LAST) ? S_START : S_PADZ;
        end
        S_PADZ: begin
          if (fill_r == LEN_START) begin
            cnt_r   <= '0;
            state_r <= S_LEN;
          end else begin
            fill_r <= fill_r + 6'd1;
            if (fill_r == FILL_LAST) state_r <= S_START;
          end
        end
        S_LEN: begin
          cnt_r  <= cnt_r + 3'd1;
          fill_r <= fill_r + 6'd1;
          if (cnt_r == 3'd7) begin
            final_r <= 1'b1;
            state_r <= S_START;
          end
        end
        S_OUT: begin
          if (out_stream.ready) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              final_r   <= 1'b0;
              padding_r <= 1'b0;
              len_r     <= '0;
              fill_r    <= '0;
              state_r   <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stream.ready        = (state_r == S_IDLE);
  assign out_stream.valid       = (state_r == S_OUT);
  assign out_stream.digest_word = chain[idx_r];
  assign out_stream.word_index  = idx_r;
  assign out_stream.last_word   = (idx_r == 3'd7);

  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_stream.ready |-> !out_stream.valid)
    else $error("input ready while digest is presented");

  a_core_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> !in_stream.ready)
    else $error("input ready during compression");

  a_word_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_stream.valid && out_stream.ready && !out_stream.last_word |=>
      out_stream.valid && out_stream.word_index == $past(out_stream.word_index) + 3'd1)
    else $error("digest word sequence broken");

endmodule

>>> sim/sha_digest_check.sv
`timescale 1ns / 1ps
module sha_digest_check import sha_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  sha_in_if    in_mon,
  sha_out_if   out_mon,
  output int   fail_count,
  output int   pending_words
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last_word;
  } digest_beat_t;

  logic [31:0]  chain_h [8];
  logic [7:0]   msg_block [64];
  int           block_fill;
  logic [63:0]  msg_bits;
  digest_beat_t digest_q [$];

  initial begin
    fail_count = 0;
    pending_words = 0;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void start_digest();
    int i;
    for (i = 0; i < 8; i++) chain_h[i] = SHA_IV[i];
    block_fill = 0;
    msg_bits = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    int t;
    for (t = 0; t < 16; t++) begin
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    end
    for (t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    for (t = 0; t < 8; t++) v[t] = chain_h[t];
    for (t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (t = 0; t < 8; t++) chain_h[t] = chain_h[t] + v[t];
  endfunction

  function automatic void absorb_item(input logic [7:0] b, input logic hb, input logic me);
    int i;
    digest_beat_t beat;
    if (hb) begin
      msg_block[block_fill] = b;
      block_fill++;
      msg_bits = msg_bits + 64'd8;
      if (block_fill == 64) begin
        compress_block();
        block_fill = 0;
      end
    end
    if (me) begin
      msg_block[block_fill] = PAD_BYTE;
      block_fill++;
      // no room for the length: pad out and spill into a second block
      if (block_fill > LEN_START) begin
        for (i = block_fill; i < 64; i++) msg_block[i] = 8'h00;
        compress_block();
        block_fill = 0;
      end
      for (i = block_fill; i < LEN_START; i++) msg_block[i] = 8'h00;
      for (i = 0; i < 8; i++) msg_block[63-i] = msg_bits[i*8 +: 8];
      compress_block();
      for (i = 0; i < 8; i++) begin
        beat.word = chain_h[i];
        beat.idx = 3'(i);
        beat.last_word = (i == 7);
        digest_q.push_back(beat);
      end
      start_digest();
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    fail_count++;
  endtask

  task automatic check_word(input logic [31:0] word, input logic [2:0] idx, input logic lw);
    digest_beat_t exp_beat;
    if (digest_q.size() == 0) begin
      report_mismatch($sformatf("unexpected digest word %08h idx %0d", word, idx));
    end else begin
      exp_beat = digest_q.pop_front();
      if (word !== exp_beat.word || idx !== exp_beat.idx || lw !== exp_beat.last_word) begin
        report_mismatch($sformatf("got word %08h idx %0d last %0b, want %08h idx %0d last %0b",
                                  word, idx, lw, exp_beat.word, exp_beat.idx,
                                  exp_beat.last_word));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start_digest();
      digest_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        absorb_item(in_mon.data_byte, in_mon.has_byte, in_mon.message_end);
      end
      if (out_mon.valid && out_mon.ready) begin
        check_word(out_mon.digest_word, out_mon.word_index, out_mon.last_word);
      end
    end
    pending_words = digest_q.size();
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_words;
  int   items_sent;
  int   burst_left;
  int   boundary_lens [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

  sha_in_if  in_if ();
  sha_out_if out_if ();

  sha256_message_digest_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_if),
    .out_stream (out_if)
  );

  sha_digest_check u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic send_item(input logic [7:0] b, input logic hb, input logic me);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_if.valid       <= 1'b1;
    in_if.data_byte   <= b;
    in_if.has_byte    <= hb;
    in_if.message_end <= me;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    burst_left--;
    if (hb || me) items_sent++;
  endtask

  task automatic send_message(input int len, input bit joined_end);
    int i;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, joined_end && (i == len - 1));
    end
    if (!joined_end || len == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // receiver stall pattern, switches between randomly chosen modes
  initial begin
    int mode;
    int phase;
    out_if.ready <= 1'b0;
    mode = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (phase % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: begin
          out_if.ready <= 1'b1;
        end
        1: begin
          out_if.ready <= 1'($urandom_range(0, 1));
        end
        2: begin
          out_if.ready <= (phase % 4 == 3);
        end
        default: begin
          out_if.ready <= (phase % 16 < 6);
        end
      endcase
      phase++;
    end
  end

  initial begin
    int len;
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.data_byte   <= 8'h00;
    in_if.has_byte    <= 1'b0;
    in_if.message_end <= 1'b0;
    burst_left = 0;
    items_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message, idle item, single-byte messages at the byte extremes
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    // "abc" with a separate end transfer
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    // idle item inside a message
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'h3c, 1'b0, 1'b0);
    send_item(8'haa, 1'b1, 1'b1);
    // back-to-back empty messages
    send_item(8'h80, 1'b0, 1'b1);
    send_item(8'h7f, 1'b0, 1'b1);

    while (items_sent < 380) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          len = $urandom_range(0, 12);
        end
        5, 6, 7, 8: begin
          len = boundary_lens[$urandom_range(0, 7)];
        end
        default: begin
          len = $urandom_range(13, 130);
        end
      endcase
      send_message(len, 1'($urandom_range(0, 1)));
    end
    in_if.valid <= 1'b0;

    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/sha_pkg.sv
hw/rtl/sha_stream_if.sv
hw/rtl/sha_round.sv
hw/rtl/sha_core.sv
hw/rtl/sha256_message_digest_top.sv
sim/sha_digest_check.sv
sim/tb_top.sv
